// ----- hdl/ssse_pkg.sv -----
// Shared types, codes and constants for the stabilizer syndrome/span engine.
// No dependencies; the interfaces, the GF(2) unit, the engine and the testbench import this package.
package ssse_pkg;

    localparam int WORD_BITS     = 64;
    localparam int DEF_MAX_QUBITS = 64;
    localparam int DEF_MAX_GENS   = 64;
    localparam int CFG_BITS      = 7;

    // Operation codes
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_SYND = 2'd1;
    localparam logic [1:0] OP_SPAN = 2'd2;
    localparam logic [1:0] OP_COMM = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_ROW  = 2'd1;
    localparam logic [1:0] ST_NONCOMM  = 2'd2;

    // Configuration register indexes
    localparam logic REG_GENS   = 1'b0;
    localparam logic REG_QUBITS = 1'b1;

    // One Pauli as x and z halves
    typedef struct packed {
        logic [WORD_BITS-1:0] z;
        logic [WORD_BITS-1:0] x;
    } pauli_t;

    // Result of the shared GF(2) unit
    typedef struct packed {
        logic   anti;   // symplectic product of a and b
        logic   hit;    // b has the pivot column set
        pauli_t low;    // lowest set column of a, one-hot
    } gf2_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SYN_RD,
        S_SYN_EX,
        S_CP_RD,
        S_CP_WR,
        S_PV_RD,
        S_PV_EX,
        S_PV_TG,
        S_EL_RD,
        S_EL_EX,
        S_CM_RI,
        S_CM_LI,
        S_CM_RD,
        S_CM_EX,
        S_FIN
    } ssse_state_t;

endpackage

// ----- hdl/ssse_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on ssse_pkg for the word width.
interface ssse_req_if import ssse_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [5:0]           row_index;
    logic [WORD_BITS-1:0] x_bits;
    logic [WORD_BITS-1:0] z_bits;
    modport source (output valid, opcode, row_index, x_bits, z_bits, input ready);
    modport sink   (input valid, opcode, row_index, x_bits, z_bits, output ready);
endinterface

interface ssse_rsp_if import ssse_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] syndrome_bits;
    logic                 in_span;
    logic                 all_commute;
    logic [1:0]           status;
    modport source (output valid, syndrome_bits, in_span, all_commute, status, input ready);
    modport sink   (input valid, syndrome_bits, in_span, all_commute, status, output ready);
endinterface

// ----- hdl/ssse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssse_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/ssse_gf2_unit.sv -----
// Shared GF(2) unit: symplectic product, pivot-column test, lowest set column.
// Depends on ssse_pkg.
module ssse_gf2_unit import ssse_pkg::*; (
    input  pauli_t   a,
    input  pauli_t   b,
    input  pauli_t   pivot_col,
    output gf2_res_t res
);
    logic [2*WORD_BITS-1:0] a_flat;

    assign a_flat   = a;
    // parity of (ax & bz) ^ (az & bx)
    assign res.anti = ^((a.x & b.z) ^ (a.z & b.x));
    assign res.hit  = |(pivot_col & b);
    // isolate lowest set bit; x half holds the low columns
    assign res.low  = a_flat & (~a_flat + {{(2*WORD_BITS-1){1'b0}}, 1'b1});
endmodule

// ----- hdl/stabilizer_syndrome_span_engine.sv -----
// Stabilizer syndrome and span engine, top level: sequencer, tables, result register.
// Depends on ssse_pkg, ssse_if, ssse_ram and ssse_gf2_unit.
//
// One request is handled at a time; the engine is busy from accept until its result
// sits in the output register. All work goes through one shared GF(2) unit fed by
// one read port per table. Syndrome and commutativity sweep the first m generator
// rows, and the span test runs copy, pivot and elimination passes over them, with
// m = generators_in_use. The next request is accepted while a finished result
// still waits to be taken.
// Reading a generator row never loaded gives undefined results.
module stabilizer_syndrome_span_engine import ssse_pkg::*; #(
    parameter int MAX_QUBITS     = DEF_MAX_QUBITS,
    parameter int MAX_GENERATORS = DEF_MAX_GENS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_BITS-1:0] cfg_wdata,
    ssse_req_if.sink            req,
    ssse_rsp_if.source          rsp
);
    localparam int AW = (MAX_GENERATORS > 1) ? $clog2(MAX_GENERATORS) : 1;
    localparam logic [CFG_BITS-1:0] MAXG = CFG_BITS'(MAX_GENERATORS);
    localparam logic [CFG_BITS-1:0] MAXQ = CFG_BITS'(MAX_QUBITS);
    localparam logic [CFG_BITS-1:0] ONE  = CFG_BITS'(1);

    // configuration registers
    logic [CFG_BITS-1:0] gens_reg, qubits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gens_reg   <= '0;
            qubits_reg <= CFG_BITS'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_GENS:   gens_reg   <= cfg_wdata;
                REG_QUBITS: qubits_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // saturated counts and qubit mask
    logic [CFG_BITS-1:0]  m_sat, q_sat;
    logic [WORD_BITS-1:0] mask_now;

    assign m_sat    = (gens_reg > MAXG) ? MAXG : gens_reg;
    assign q_sat    = (qubits_reg > MAXQ) ? MAXQ : qubits_reg;
    assign mask_now = (q_sat >= CFG_BITS'(WORD_BITS)) ? '1
                    : ((WORD_BITS'(1) << q_sat) - WORD_BITS'(1));

    // sequencer and datapath registers
    ssse_state_t          state_reg, state_next;
    logic [CFG_BITS-1:0]  i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic [WORD_BITS-1:0] mask_reg, mask_next, syn_reg, syn_next;
    pauli_t               tgt_reg, tgt_next, piv_reg, piv_next;
    pauli_t               pcol_reg, pcol_next, ai_reg, ai_next;
    logic                 span_reg, span_next, comm_reg, comm_next;
    logic [1:0]           st_reg, st_next;
    logic [1:0]           op_reg, op_next;

    // output register
    logic                 ov_reg, ov_next;
    logic [WORD_BITS-1:0] o_syn_reg, o_syn_next;
    logic                 o_span_reg, o_span_next, o_comm_reg, o_comm_next;
    logic [1:0]           o_st_reg, o_st_next;

    // memories
    logic            gen_we, work_we;
    logic [AW-1:0]   gen_waddr, gen_raddr, work_waddr, work_raddr;
    pauli_t          gen_wdata, work_wdata, gen_rd, work_rd, gen_m;
    logic            accept, row_ok;

    ssse_ram #(.WIDTH(2*WORD_BITS), .DEPTH(MAX_GENERATORS), .AW(AW)) u_gen_ram (
        .clk   (clk),
        .we    (gen_we),
        .waddr (gen_waddr),
        .wdata (gen_wdata),
        .raddr (gen_raddr),
        .rdata (gen_rd)
    );

    ssse_ram #(.WIDTH(2*WORD_BITS), .DEPTH(MAX_GENERATORS), .AW(AW)) u_work_ram (
        .clk   (clk),
        .we    (work_we),
        .waddr (work_waddr),
        .wdata (work_wdata),
        .raddr (work_raddr),
        .rdata (work_rd)
    );

    assign gen_m.x = gen_rd.x & mask_reg;
    assign gen_m.z = gen_rd.z & mask_reg;

    // shared GF(2) unit operand selection
    pauli_t   alu_a, alu_b;
    gf2_res_t alu;

    always_comb
    begin
        case (state_reg)
            S_CM_EX: alu_a = ai_reg;
            S_PV_EX: alu_a = work_rd;
            default: alu_a = gen_m;
        endcase
        case (state_reg)
            S_CM_EX: alu_b = gen_m;
            S_EL_EX: alu_b = work_rd;
            default: alu_b = tgt_reg;
        endcase
    end

    ssse_gf2_unit u_gf2 (
        .a         (alu_a),
        .b         (alu_b),
        .pivot_col (pcol_reg),
        .res       (alu)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign row_ok    = ({1'b0, req.row_index} < MAXG);

    // loads write the generator table straight from the request
    assign gen_we       = accept && (req.opcode == OP_LOAD) && row_ok;
    assign gen_waddr    = req.row_index[AW-1:0];
    assign gen_wdata.x  = req.x_bits & mask_now;
    assign gen_wdata.z  = req.z_bits & mask_now;

    assign rsp.valid         = ov_reg;
    assign rsp.syndrome_bits = o_syn_reg;
    assign rsp.in_span       = o_span_reg;
    assign rsp.all_commute   = o_comm_reg;
    assign rsp.status        = o_st_reg;

    // next state and datapath
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        m_next      = m_reg;
        mask_next   = mask_reg;
        syn_next    = syn_reg;
        tgt_next    = tgt_reg;
        piv_next    = piv_reg;
        pcol_next   = pcol_reg;
        ai_next     = ai_reg;
        span_next   = span_reg;
        comm_next   = comm_reg;
        st_next     = st_reg;
        op_next     = op_reg;
        ov_next     = ov_reg && !rsp.ready;
        o_syn_next  = o_syn_reg;
        o_span_next = o_span_reg;
        o_comm_next = o_comm_reg;
        o_st_next   = o_st_reg;
        gen_raddr   = i_reg[AW-1:0];
        work_raddr  = i_reg[AW-1:0];
        work_we     = 1'b0;
        work_waddr  = i_reg[AW-1:0];
        work_wdata  = gen_m;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.opcode;
                    m_next     = m_sat;
                    mask_next  = mask_now;
                    tgt_next.x = req.x_bits & mask_now;
                    tgt_next.z = req.z_bits & mask_now;
                    syn_next   = '0;
                    span_next  = 1'b0;
                    comm_next  = 1'b0;
                    st_next    = ST_OK;
                    i_next     = '0;
                    case (req.opcode)
                        OP_LOAD:
                        begin
                            st_next    = row_ok ? ST_OK : ST_BAD_ROW;
                            state_next = S_FIN;
                        end
                        OP_SYND: state_next = (m_sat == '0) ? S_FIN : S_SYN_RD;
                        OP_SPAN: state_next = (m_sat == '0) ? S_PV_RD : S_CP_RD;
                        default:
                        begin
                            comm_next  = 1'b1;
                            state_next = (m_sat <= ONE) ? S_FIN : S_CM_RI;
                        end
                    endcase
                end
            end
            // syndrome: one generator row per visit
            S_SYN_RD: state_next = S_SYN_EX;
            S_SYN_EX:
            begin
                syn_next   = syn_reg | (WORD_BITS'(alu.anti) << i_reg[5:0]);
                i_next     = i_reg + ONE;
                state_next = (i_reg + ONE >= m_reg) ? S_FIN : S_SYN_RD;
            end
            // span: copy masked generators into the workspace
            S_CP_RD: state_next = S_CP_WR;
            S_CP_WR:
            begin
                work_we = 1'b1;
                if (i_reg + ONE >= m_reg)
                begin
                    i_next     = '0;
                    state_next = S_PV_RD;
                end
                else
                begin
                    i_next     = i_reg + ONE;
                    state_next = S_CP_RD;
                end
            end
            // span: fetch pivot row i
            S_PV_RD:
            begin
                if (i_reg >= m_reg)
                begin
                    span_next  = (tgt_reg == '0);
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_PV_EX;
                end
            end
            S_PV_EX:
            begin
                piv_next  = work_rd;
                pcol_next = alu.low;
                if (alu.low == '0)
                begin
                    i_next     = i_reg + ONE;
                    state_next = S_PV_RD;
                end
                else
                begin
                    state_next = S_PV_TG;
                end
            end
            // span: reduce the target, then later rows
            S_PV_TG:
            begin
                if (alu.hit)
                begin
                    tgt_next = tgt_reg ^ piv_reg;
                end
                j_next = i_reg + ONE;
                if (i_reg + ONE >= m_reg)
                begin
                    i_next     = i_reg + ONE;
                    state_next = S_PV_RD;
                end
                else
                begin
                    state_next = S_EL_RD;
                end
            end
            S_EL_RD:
            begin
                work_raddr = j_reg[AW-1:0];
                state_next = S_EL_EX;
            end
            S_EL_EX:
            begin
                work_waddr = j_reg[AW-1:0];
                work_wdata = work_rd ^ piv_reg;
                work_we    = alu.hit;
                if (j_reg + ONE >= m_reg)
                begin
                    i_next     = i_reg + ONE;
                    state_next = S_PV_RD;
                end
                else
                begin
                    j_next     = j_reg + ONE;
                    state_next = S_EL_RD;
                end
            end
            // commutativity: hold row i, sweep rows j above it
            S_CM_RI: state_next = S_CM_LI;
            S_CM_LI:
            begin
                ai_next = gen_m;
                j_next  = i_reg + ONE;
                state_next = (i_reg + ONE >= m_reg) ? S_FIN : S_CM_RD;
            end
            S_CM_RD:
            begin
                gen_raddr  = j_reg[AW-1:0];
                state_next = S_CM_EX;
            end
            S_CM_EX:
            begin
                if (alu.anti)
                begin
                    comm_next  = 1'b0;
                    st_next    = ST_NONCOMM;
                    state_next = S_FIN;
                end
                else if (j_reg + ONE >= m_reg)
                begin
                    i_next     = i_reg + ONE;
                    state_next = S_CM_RI;
                end
                else
                begin
                    j_next     = j_reg + ONE;
                    state_next = S_CM_RD;
                end
            end
            // hand the result to the output register once it is free
            S_FIN:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next     = 1'b1;
                    o_syn_next  = (op_reg == OP_SYND) ? syn_reg : '0;
                    o_span_next = (op_reg == OP_SPAN) && span_reg;
                    o_comm_next = (op_reg == OP_COMM) && comm_reg;
                    o_st_next   = st_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            tgt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            tgt_reg   <= tgt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        m_reg      <= m_next;
        mask_reg   <= mask_next;
        syn_reg    <= syn_next;
        piv_reg    <= piv_next;
        pcol_reg   <= pcol_next;
        ai_reg     <= ai_next;
        span_reg   <= span_next;
        comm_reg   <= comm_next;
        st_reg     <= st_next;
        op_reg     <= op_next;
        o_syn_reg  <= o_syn_next;
        o_span_reg <= o_span_next;
        o_comm_reg <= o_comm_next;
        o_st_reg   <= o_st_next;
    end

    // checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("engine ready right after accepting a transaction");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.in_span && rsp.all_commute))
        else $error("span and commute flags both set");

    a_noncomm_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == ST_NONCOMM)) |-> !rsp.all_commute)
        else $error("noncommuting status with all_commute set");

endmodule

// ----- dv/tb_stabilizer_syndrome_span_engine.sv -----
// Testbench for the stabilizer syndrome/span engine: directed table, then random phases.
// Depends on ssse_pkg, ssse_if and the engine RTL; results checked against a local predictor.
`timescale 1ns / 1ps

module tb_stabilizer_syndrome_span_engine;
    import ssse_pkg::*;

    typedef struct packed {
        logic [WORD_BITS-1:0] syn;
        logic                 span;
        logic                 comm;
        logic [1:0]           status;
    } outcome_t;

    typedef struct {
        logic [1:0]           op;
        logic [5:0]           row;
        logic [WORD_BITS-1:0] x;
        logic [WORD_BITS-1:0] z;
        int                   gens;
        bit                   typed;
        outcome_t             want;
    } vector_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic                cfg_index;
    logic [CFG_BITS-1:0] cfg_wdata;

    ssse_req_if req ();
    ssse_rsp_if rsp ();

    stabilizer_syndrome_span_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    // Shadow copy of the generator table and registers
    logic [WORD_BITS-1:0] gen_x_shadow [64];
    logic [WORD_BITS-1:0] gen_z_shadow [64];
    int gens_reg   = 0;
    int qubits_reg = 64;

    outcome_t pending_results [$];
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       hold_req = 0;
    int       hold_cnt = 0;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bits of the qubits in use, saturated at 64
    function automatic logic [WORD_BITS-1:0] qubit_mask();
        int n;
        n = (qubits_reg > 64) ? 64 : qubits_reg;
        if (n >= 64)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic anticommutes(logic [63:0] ax, logic [63:0] az,
                                          logic [63:0] bx, logic [63:0] bz);
        return ^((ax & bz) ^ (az & bx));
    endfunction

    // Applies one transaction to the shadow state and returns its outcome
    function automatic outcome_t evaluate(logic [1:0] op, logic [5:0] row,
                                          logic [63:0] x, logic [63:0] z);
        logic [63:0]  m;
        logic [63:0]  px;
        logic [63:0]  pz;
        logic [127:0] wrk [64];
        logic [127:0] tgt;
        int           g;
        int           c;
        outcome_t     o;
        o  = '0;
        m  = qubit_mask();
        px = x & m;
        pz = z & m;
        g  = (gens_reg > 64) ? 64 : gens_reg;
        case (op)
            OP_LOAD:
            begin
                gen_x_shadow[row] = px;
                gen_z_shadow[row] = pz;
                o.status = ST_OK;
            end
            OP_SYND:
            begin
                for (int i = 0; i < g; i++)
                    o.syn[i] = anticommutes(gen_x_shadow[i] & m, gen_z_shadow[i] & m, px, pz);
            end
            OP_SPAN:
            begin
                for (int i = 0; i < g; i++)
                    wrk[i] = {gen_z_shadow[i] & m, gen_x_shadow[i] & m};
                tgt = {pz, px};
                // echelon reduction on symplectic columns, x half first
                for (int i = 0; i < g; i++)
                begin
                    c = -1;
                    for (int b = 0; b < 128; b++)
                        if (c < 0 && wrk[i][b])
                            c = b;
                    if (c >= 0)
                    begin
                        for (int j = i + 1; j < g; j++)
                            if (wrk[j][c])
                                wrk[j] ^= wrk[i];
                        if (tgt[c])
                            tgt ^= wrk[i];
                    end
                end
                o.span = (tgt == '0);
            end
            default:
            begin
                o.comm = 1'b1;
                for (int i = 0; i < g; i++)
                    for (int j = i + 1; j < g; j++)
                        if (anticommutes(gen_x_shadow[i] & m, gen_z_shadow[i] & m,
                                         gen_x_shadow[j] & m, gen_z_shadow[j] & m))
                            o.comm = 1'b0;
                if (!o.comm)
                    o.status = ST_NONCOMM;
            end
        endcase
        return o;
    endfunction

    // Offer one transaction and record its expected outcome once accepted
    task automatic offer(logic [1:0] op, logic [5:0] row, logic [63:0] x, logic [63:0] z,
                         bit typed, outcome_t want);
        outcome_t got;
        req.valid     <= 1'b1;
        req.opcode    <= op;
        req.row_index <= row;
        req.x_bits    <= x;
        req.z_bits    <= z;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        got = evaluate(op, row, x, z);
        pending_results.push_back(typed ? want : got);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write, only with the engine idle
    task automatic write_reg(logic idx, int val);
        drain();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_BITS-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_GENS)
            gens_reg = val;
        else
            qubits_reg = val;
    endtask

    // One random transaction; x_only keeps loaded rows mutually commuting
    task automatic random_item(bit x_only);
        int           r;
        int           g;
        logic [63:0]  x;
        logic [63:0]  z;
        logic [63:0]  m;
        r = $urandom_range(99);
        g = (gens_reg > 64) ? 64 : gens_reg;
        m = qubit_mask();
        x = {$urandom, $urandom};
        z = {$urandom, $urandom};
        if (r < 25)
            offer(OP_LOAD, 6'($urandom_range(63)), x, x_only ? 64'd0 : z, 1'b0, '0);
        else if (r < 50)
            offer(OP_SYND, 6'($urandom_range(63)), x, z, 1'b0, '0);
        else if (r < 80)
        begin
            // mostly sums of generators, with noise above the qubit mask
            if ($urandom_range(99) < 65)
            begin
                x = {$urandom, $urandom} & ~m;
                z = {$urandom, $urandom} & ~m;
                for (int i = 0; i < g; i++)
                    if ($urandom_range(1))
                    begin
                        x ^= gen_x_shadow[i];
                        z ^= gen_z_shadow[i];
                    end
                if ($urandom_range(99) < 15)
                    x[$urandom_range(63)] ^= 1'b1;
            end
            offer(OP_SPAN, 6'($urandom_range(63)), x, z, 1'b0, '0);
        end
        else
            offer(OP_COMM, 6'($urandom_range(63)), x, z, 1'b0, '0);
    endtask

    // Result side: check, then choose ready for the next edge
    always @(posedge clk)
    begin
        outcome_t exp_res;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction");
                mismatches++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (rsp.syndrome_bits !== exp_res.syn)
                begin
                    $error("syndrome_bits expected %h actual %h", exp_res.syn, rsp.syndrome_bits);
                    mismatches++;
                end
                if (rsp.in_span !== exp_res.span)
                begin
                    $error("in_span expected %b actual %b", exp_res.span, rsp.in_span);
                    mismatches++;
                end
                if (rsp.all_commute !== exp_res.comm)
                begin
                    $error("all_commute expected %b actual %b", exp_res.comm, rsp.all_commute);
                    mismatches++;
                end
                if (rsp.status !== exp_res.status)
                begin
                    $error("status expected %0d actual %0d", exp_res.status, rsp.status);
                    mismatches++;
                end
            end
        end
        if (hold_req > 0)
        begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Run limit
    initial
    begin
        #40_000_000;
        $display("stabilizer_syndrome_span_engine verification failed");
        $finish;
    end

    // Stimulus
    initial
    begin
        vector_t plan [14];
        int      gens_list  [14] = '{1, 3, 5, 8, 2, 12, 64, 127, 4, 6, 10, 7, 3, 0};
        int      qubit_list [14] = '{64, 1, 0, 17, 127, 40, 64, 64, 33, 5, 64, 2, 63, 64};
        int      count_list [14] = '{120, 120, 120, 140, 120, 120, 30, 20, 120, 120, 120,
                                     120, 120, 60};
        bit      style_list [14] = '{0, 1, 0, 1, 0, 0, 1, 0, 1, 0, 1, 0, 0, 1};
        int      g;

        plan = '{
            '{OP_SYND, 6'd0,  '1,      '1,      0, 1, '{64'd0, 1'b0, 1'b0, ST_OK}},
            '{OP_SPAN, 6'd0,  64'd0,   64'd0,   0, 1, '{64'd0, 1'b1, 1'b0, ST_OK}},
            '{OP_SPAN, 6'd0,  64'd1,   64'd0,   0, 1, '{64'd0, 1'b0, 1'b0, ST_OK}},
            '{OP_SPAN, 6'd63, 64'd0,   64'h8000_0000_0000_0000, 0, 1,
              '{64'd0, 1'b0, 1'b0, ST_OK}},
            '{OP_COMM, 6'd0,  64'd0,   64'd0,   0, 1, '{64'd0, 1'b0, 1'b1, ST_OK}},
            '{OP_LOAD, 6'd0,  '1,      64'd0,   0, 1, '{64'd0, 1'b0, 1'b0, ST_OK}},
            '{OP_LOAD, 6'd63, 64'd0,   '1,      0, 1, '{64'd0, 1'b0, 1'b0, ST_OK}},
            '{OP_LOAD, 6'd1,  64'd0,   64'd1,   0, 1, '{64'd0, 1'b0, 1'b0, ST_OK}},
            '{OP_SYND, 6'd0,  64'd1,   64'd0,   2, 0, '0},
            '{OP_SPAN, 6'd0,  '1,      64'd1,   2, 0, '0},
            '{OP_COMM, 6'd0,  64'd0,   64'd0,   2, 1, '{64'd0, 1'b0, 1'b0, ST_NONCOMM}},
            '{OP_SYND, 6'd0,  64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 2, 0, '0},
            '{OP_LOAD, 6'd0,  64'd0,   64'd0,   2, 1, '{64'd0, 1'b0, 1'b0, ST_OK}},
            '{OP_COMM, 6'd0,  64'd0,   64'd0,   2, 1, '{64'd0, 1'b0, 1'b1, ST_OK}}
        };

        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_GENS;
        cfg_wdata     = '0;
        req.valid     = 1'b0;
        req.opcode    = OP_LOAD;
        req.row_index = '0;
        req.x_bits    = '0;
        req.z_bits    = '0;
        rsp.ready     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty table, extremes, a small two-row set
        foreach (plan[k])
        begin
            if (plan[k].gens != gens_reg)
                write_reg(REG_GENS, plan[k].gens);
            offer(plan[k].op, plan[k].row, plan[k].x, plan[k].z, plan[k].typed, plan[k].want);
        end
        write_reg(REG_QUBITS, 64);

        // Fill every row so that any generator count reads written rows only
        for (int r = 0; r < 64; r++)
            offer(OP_LOAD, 6'(r), {$urandom, $urandom}, {$urandom, $urandom}, 1'b0, '0);

        // Random phases over register settings and idle patterns
        for (int p = 0; p < 14; p++)
        begin
            write_reg(REG_GENS, gens_list[p]);
            write_reg(REG_QUBITS, qubit_list[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            g = (gens_reg > 64) ? 64 : gens_reg;
            if (style_list[p])
                for (int r = 0; r < g; r++)
                    offer(OP_LOAD, 6'(r), {$urandom, $urandom}, 64'd0, 1'b0, '0);
            if (p == 3)
                hold_req = 400;
            for (int n = 0; n < count_list[p]; n++)
            begin
                if (p == 5 && n == count_list[p] / 2)
                    drain();
                random_item(style_list[p]);
            end
        end

        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("stabilizer_syndrome_span_engine verification clean");
        else
            $display("stabilizer_syndrome_span_engine verification failed");
        $finish;
    end

endmodule
